@@ rtl/core/dht_pkg.sv @@
package dht_pkg;

  localparam int unsigned Slots  = 64;
  localparam int unsigned KeyW   = 31;
  localparam int unsigned SizeW  = 7;
  localparam int unsigned OutSlotW = 6;
  localparam int unsigned DumpMax  = 64;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_DUMP   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_DUMP      = 3'd4
  } status_e;

  localparam logic CFG_TABLE_SIZE = 1'b0;
  localparam logic CFG_SECOND_MOD = 1'b1;

  typedef struct packed {
    action_e           action;
    logic [KeyW-1:0]   key;
    logic [SizeW-1:0]  home;
    logic [SizeW-1:0]  step;
    logic [SizeW-1:0]  n;
  } job_t;

  typedef struct packed {
    status_e              status;
    logic [OutSlotW-1:0]  slot;
    logic [OutSlotW-1:0]  collisions;
    logic [KeyW-1:0]      entry_key;
    logic                 last;
  } res_t;

endpackage

@@ rtl/core/dht_fifo.sv @@
module dht_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  dht_pkg::job_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output dht_pkg::job_t rd_data_o
);
  import dht_pkg::*;

  job_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = mem_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/core/dht_front.sv @@
module dht_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic [dht_pkg::SizeW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  action_i,
  input  logic [dht_pkg::KeyW-1:0]    key_i,
  output logic                        job_valid_o,
  input  logic                        job_ready_i,
  output dht_pkg::job_t               job_o
);
  import dht_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_e;

  front_state_e     state_q, state_d;
  logic [SizeW-1:0] tsize_q, qmod_q;
  logic [SizeW-1:0] n_eff, q_eff, q_q;
  logic [SizeW-1:0] rn_q, rq_q, rn_d, rq_d;
  logic [4:0]       bit_q;
  logic [SizeW:0]   tn, tq;
  job_t             job_q;
  logic             accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == F_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign job_valid_o = (state_q == F_PUSH);
  assign job_o       = job_q;

  always_comb begin
    n_eff = tsize_q;
    if (tsize_q == '0) n_eff = SizeW'(1);
    else if (32'(tsize_q) > Slots) n_eff = SizeW'(Slots);
    q_eff = qmod_q;
    if (qmod_q == '0) q_eff = SizeW'(1);
    else if (qmod_q > n_eff) q_eff = n_eff;
  end

  // One key bit per cycle into both remainders, most significant bit first.
  always_comb begin
    tn = {rn_q, job_q.key[bit_q]};
    tq = {rq_q, job_q.key[bit_q]};
    if (tn >= {1'b0, job_q.n}) tn = tn - {1'b0, job_q.n};
    if (tq >= {1'b0, q_q}) tq = tq - {1'b0, q_q};
    rn_d = tn[SizeW-1:0];
    rq_d = tq[SizeW-1:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          if (action_e'(action_i) == ACT_NONE) state_d = F_IDLE;
          else if (action_e'(action_i) == ACT_DUMP || key_i == '0) state_d = F_PUSH;
          else state_d = F_DIV;
        end
      end
      F_DIV: begin
        if (bit_q == 5'd0) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (job_ready_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      tsize_q <= SizeW'(64);
      qmod_q  <= SizeW'(1);
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_TABLE_SIZE) tsize_q <= cfg_data_i;
        else if (cfg_index_i == CFG_SECOND_MOD) qmod_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q.action <= action_e'(action_i);
      job_q.key    <= key_i;
      job_q.n      <= n_eff;
      job_q.home   <= '0;
      job_q.step   <= '0;
      q_q          <= q_eff;
      rn_q         <= '0;
      rq_q         <= '0;
      bit_q        <= 5'(KeyW - 1);
    end else if (state_q == F_DIV) begin
      rn_q  <= rn_d;
      rq_q  <= rq_d;
      bit_q <= bit_q - 5'd1;
      if (bit_q == 5'd0) begin
        job_q.home <= rn_d;
        job_q.step <= q_q - rq_d;
      end
    end
  end

endmodule

@@ rtl/core/dht_back.sv @@
module dht_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  dht_pkg::job_t job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dht_pkg::res_t res_o
);
  import dht_pkg::*;

  localparam int unsigned AW = $clog2(Slots);

  typedef enum logic [2:0] {
    B_CLEAR, B_IDLE, B_PRD, B_PCHK, B_NOKEY, B_DRD, B_DCHK
  } back_state_e;

  back_state_e      state_q, state_d;
  job_t             job_q, job_d;
  logic [SizeW-1:0] b_q, b_d, i_q, i_d, dump_cnt;
  logic [AW-1:0]    clr_q, clr_d, raddr, waddr;
  logic [KeyW-1:0]  mem [Slots];
  logic [KeyW-1:0]  rdata_q, wdata, v;
  logic             we, load, out_valid_q, out_free, last_probe;
  res_t             out_q, res_d;
  logic [SizeW:0]   bsum;
  logic [SizeW-1:0] b_next;

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign job_ready_o = (state_q == B_IDLE);
  assign v           = rdata_q;
  assign dump_cnt    = (job_q.n < SizeW'(DumpMax)) ? job_q.n : SizeW'(DumpMax);
  assign last_probe  = (i_q + SizeW'(1) == job_q.n);

  always_comb begin
    bsum = {1'b0, b_q} + {1'b0, job_q.step};
    if (bsum >= {1'b0, job_q.n}) bsum = bsum - {1'b0, job_q.n};
    b_next = bsum[SizeW-1:0];
  end

  assign raddr = (state_q == B_DRD || state_q == B_DCHK) ? AW'(i_q) : AW'(b_q);

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    b_d     = b_q;
    i_d     = i_q;
    clr_d   = clr_q;
    we      = 1'b0;
    waddr   = AW'(b_q);
    wdata   = job_q.key;
    load    = 1'b0;
    res_d   = '0;
    res_d.last = 1'b1;
    unique case (state_q)
      B_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(Slots - 1)) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (job_valid_i) begin
          job_d = job_i;
          b_d   = job_i.home;
          i_d   = '0;
          if (job_i.action == ACT_DUMP) state_d = B_DRD;
          else if (job_i.key == '0) state_d = B_NOKEY;
          else state_d = B_PRD;
        end
      end
      B_PRD: state_d = B_PCHK;
      B_PCHK: begin
        if (job_q.action == ACT_INSERT && v == '0) begin
          res_d.status     = ST_INSERTED;
          res_d.slot       = OutSlotW'(b_q);
          res_d.collisions = OutSlotW'(i_q);
          if (out_free) begin
            we      = 1'b1;
            load    = 1'b1;
            state_d = B_IDLE;
          end
        end else if (job_q.action != ACT_INSERT && v == '0) begin
          res_d.status = ST_NOT_FOUND;
          if (out_free) begin
            load    = 1'b1;
            state_d = B_IDLE;
          end
        end else if (job_q.action != ACT_INSERT && v == job_q.key) begin
          res_d.status    = ST_FOUND;
          res_d.slot      = OutSlotW'(b_q);
          res_d.entry_key = job_q.key;
          if (out_free) begin
            load    = 1'b1;
            state_d = B_IDLE;
          end
        end else if (last_probe) begin
          res_d.status = (job_q.action == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
          if (out_free) begin
            load    = 1'b1;
            state_d = B_IDLE;
          end
        end else begin
          b_d     = b_next;
          i_d     = i_q + SizeW'(1);
          state_d = B_PRD;
        end
      end
      B_NOKEY: begin
        res_d.status = ST_NOT_FOUND;
        if (out_free) begin
          load    = 1'b1;
          state_d = B_IDLE;
        end
      end
      B_DRD: state_d = B_DCHK;
      B_DCHK: begin
        res_d.status    = ST_DUMP;
        res_d.slot      = OutSlotW'(i_q);
        res_d.entry_key = v;
        res_d.last      = (i_q + SizeW'(1) == dump_cnt);
        if (out_free) begin
          load = 1'b1;
          if (res_d.last) begin
            state_d = B_IDLE;
          end else begin
            i_d     = i_q + SizeW'(1);
            state_d = B_DRD;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    b_q   <= b_d;
    i_q   <= i_d;
    if (load) out_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_PCHK) |-> (b_q < job_q.n && i_q < job_q.n))
    else $error("probe slot or count beyond table size");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_DUMP) |-> out_q.last)
    else $error("single result word not marked last");

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_CLEAR) |-> !job_ready_o)
    else $error("job taken during clearing pass");

  a_insert_zero_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_INSERTED) |-> (out_q.entry_key == '0))
    else $error("insert result carries a key");

endmodule

@@ rtl/core/double_hash_table_top.sv @@
// Channel   Direction  Handshake                Word
// cfg       in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
// in        in         in_valid_i/in_ready_o    action_i, key_i
// out       out        out_valid_o/out_ready_i  status_o, slot_o, collisions_o,
//                                               entry_key_o, last_o
// After reset the back end clears all 64 table entries, one per cycle, before it takes work.
// For insert and search with a nonzero key the front end computes its two bit-serial remainders.
// The back end then probes by a registered read of the table memory (B_PRD) and a check (B_PCHK).
// A dump reads each entry in B_DRD and outputs it from B_DCHK; a two-entry queue lets the
// front take the next word while the back end probes or waits on a stalled output register.
module double_hash_table_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [dht_pkg::SizeW-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 action_i,
  input  logic [dht_pkg::KeyW-1:0]   key_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [2:0]                 status_o,
  output logic [5:0]                 slot_o,
  output logic [5:0]                 collisions_o,
  output logic [dht_pkg::KeyW-1:0]   entry_key_o,
  output logic                       last_o
);
  import dht_pkg::*;

  job_t fj, bj;
  logic f_valid, f_ready, b_valid, b_ready;
  res_t res;

  dht_front u_front (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .action_i, .key_i,
    .job_valid_o(f_valid), .job_ready_i(f_ready), .job_o(fj)
  );

  dht_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(fj),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(bj)
  );

  dht_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(b_valid), .job_ready_o(b_ready), .job_i(bj),
    .out_valid_o, .out_ready_i, .res_o(res)
  );

  assign status_o     = res.status;
  assign slot_o       = res.slot;
  assign collisions_o = res.collisions;
  assign entry_key_o  = res.entry_key;
  assign last_o       = res.last;

endmodule
